// ===== sv/assert_macros.svh =====
// Assertion shorthands used by the sfu_chk checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while rst_ni is low.
`define SFU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent check on clk_i that also holds through reset.
`define SFU_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ===== sv/sfu_pkg.sv =====
package sfu_pkg;

  // Field and register widths
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned RootW = 32;

  // Register reset values (Q16.16)
  localparam logic [CfgW-1:0] MaxSpeedRst  = 31'd6553600;
  localparam logic [CfgW-1:0] MaxForceRst  = 31'd327680;
  localparam logic [CfgW-1:0] SlowRadRst   = 31'd9830400;

  // Cap on the pursue offset, 2^40
  localparam logic [40:0] PursueCap = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    OP_SEEK   = 2'd0,
    OP_FLEE   = 2'd1,
    OP_ARRIVE = 2'd2,
    OP_PURSUE = 2'd3
  } op_e;

  typedef enum logic [IdxW-1:0] {
    REG_MAX_SPEED      = 2'd0,
    REG_MAX_FORCE      = 2'd1,
    REG_SLOWING_RADIUS = 2'd2
  } reg_e;

  // Everything an item carries down the pipeline
  typedef struct packed {
    op_e                op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tvx;
    logic signed [31:0] tvy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               negx;
    logic               negy;
    logic               sh;
    logic [30:0]        mx;
    logic [30:0]        my;
    logic [RootW-1:0]   len;
    logic [30:0]        qx;
    logic [30:0]        qy;
    logic               flg;
    logic               capx;
    logic               capy;
  } ctx_t;

endpackage

// ===== sv/sfu_div.sv =====
module sfu_div
  import sfu_pkg::*;
#(
  parameter int unsigned NumW  = 62,
  parameter int unsigned DenW  = RootW,
  parameter int unsigned QuoW  = CfgW,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_x_i,
  input  logic [NumW-1:0]  num_y_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QuoW-1:0]  quo_x_o,
  output logic [QuoW-1:0]  quo_y_o,
  output logic [SideW-1:0] side_o
);

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic logic [DenW+QuoW-1:0] div_step(logic [DenW-1:0] rem,
                                                    logic [QuoW-1:0] low,
                                                    logic [DenW-1:0] den);
    logic [DenW:0] t;
    logic          ge;
    t  = {rem, low[QuoW-1]};
    ge = (t >= {1'b0, den});
    if (ge) begin
      t = t - {1'b0, den};
    end
    return {t[DenW-1:0], low[QuoW-2:0], ge};
  endfunction

  logic [QuoW-1:0]  valid_q, valid_d;
  logic [DenW-1:0]  rx_q [QuoW];
  logic [DenW-1:0]  rx_d [QuoW];
  logic [DenW-1:0]  ry_q [QuoW];
  logic [DenW-1:0]  ry_d [QuoW];
  logic [QuoW-1:0]  lx_q [QuoW];
  logic [QuoW-1:0]  lx_d [QuoW];
  logic [QuoW-1:0]  ly_q [QuoW];
  logic [QuoW-1:0]  ly_d [QuoW];
  logic [DenW-1:0]  den_q [QuoW];
  logic [DenW-1:0]  den_d [QuoW];
  logic [SideW-1:0] side_q [QuoW];
  logic [SideW-1:0] side_d [QuoW];

  // One quotient bit per stage; the numerator's high part seeds the remainder
  always_comb begin
    for (int k = 0; k < QuoW; k++) begin
      if (k == 0) begin
        {rx_d[k], lx_d[k]} = div_step(DenW'(num_x_i >> QuoW), num_x_i[QuoW-1:0], den_i);
        {ry_d[k], ly_d[k]} = div_step(DenW'(num_y_i >> QuoW), num_y_i[QuoW-1:0], den_i);
        den_d[k]   = den_i;
        side_d[k]  = side_i;
        valid_d[k] = valid_i;
      end else begin
        {rx_d[k], lx_d[k]} = div_step(rx_q[k-1], lx_q[k-1], den_q[k-1]);
        {ry_d[k], ly_d[k]} = div_step(ry_q[k-1], ly_q[k-1], den_q[k-1]);
        den_d[k]   = den_q[k-1];
        side_d[k]  = side_q[k-1];
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      lx_q   <= lx_d;
      ly_q   <= ly_d;
      den_q  <= den_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q[QuoW-1];
  assign quo_x_o = lx_q[QuoW-1];
  assign quo_y_o = ly_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

// ===== sv/sfu_sqrt.sv =====
module sfu_sqrt
  import sfu_pkg::*;
#(
  parameter int unsigned RtW   = RootW,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [2*RtW-1:0] rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [RtW-1:0]   root_o,
  output logic [SideW-1:0] side_o
);

  // One digit step: bring down two radicand bits, try 4*root+1.
  function automatic logic [RtW+1+RtW+2*RtW-1:0] sq_step(logic [RtW:0]     rem,
                                                         logic [RtW-1:0]   root,
                                                         logic [2*RtW-1:0] rad);
    logic [RtW+2:0] t;
    logic [RtW+2:0] trial;
    logic           ge;
    t     = {rem, rad[2*RtW-1 -: 2]};
    trial = {1'b0, root, 2'b01};
    ge    = (t >= trial);
    if (ge) begin
      t = t - trial;
    end
    return {t[RtW:0], root[RtW-2:0], ge, rad[2*RtW-3:0], 2'b00};
  endfunction

  logic [RtW-1:0]   valid_q, valid_d;
  logic [RtW:0]     rem_q  [RtW];
  logic [RtW:0]     rem_d  [RtW];
  logic [RtW-1:0]   root_q [RtW];
  logic [RtW-1:0]   root_d [RtW];
  logic [2*RtW-1:0] rad_q  [RtW];
  logic [2*RtW-1:0] rad_d  [RtW];
  logic [SideW-1:0] side_q [RtW];
  logic [SideW-1:0] side_d [RtW];

  // One root bit per stage
  always_comb begin
    for (int k = 0; k < RtW; k++) begin
      if (k == 0) begin
        {rem_d[k], root_d[k], rad_d[k]} = sq_step('0, '0, rad_i);
        side_d[k]  = side_i;
        valid_d[k] = valid_i;
      end else begin
        {rem_d[k], root_d[k], rad_d[k]} = sq_step(rem_q[k-1], root_q[k-1], rad_q[k-1]);
        side_d[k]  = side_q[k-1];
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q[RtW-1];
  assign root_o  = root_q[RtW-1];
  assign side_o  = side_q[RtW-1];

endmodule

// ===== sv/steering_force_unit_core.sv =====
// Steering force unit: seek, flee, arrive and pursue on Q16.16 vectors. It takes
// one item per clock while the output is not stalled and returns one result per item,
// in order. It is built around three 32-stage square-root pipelines (pursue distance,
// aim distance, force length) and four one-bit-per-stage divider pipelines (41 stages
// for the pursue prediction, 31 for the desired velocity, the arrive scaling and the
// force clamp). A stall at the output freezes the whole pipeline; in_ready_o is low
// only while a result waits. Registers are written by the user only while the unit
// is idle, via cfg_we_i/cfg_idx_i/cfg_data_i; the block does not enforce it.
module steering_force_unit_core
  import sfu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IdxW-1:0]         cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              operation_i,
  input  logic signed [DataW-1:0] agent_x_i,
  input  logic signed [DataW-1:0] agent_y_i,
  input  logic signed [DataW-1:0] agent_vx_i,
  input  logic signed [DataW-1:0] agent_vy_i,
  input  logic signed [DataW-1:0] target_x_i,
  input  logic signed [DataW-1:0] target_y_i,
  input  logic signed [DataW-1:0] target_vx_i,
  input  logic signed [DataW-1:0] target_vy_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] force_x_o,
  output logic signed [DataW-1:0] force_y_o,
  output logic signed [DataW-1:0] aim_x_o,
  output logic signed [DataW-1:0] aim_y_o
);

  localparam int unsigned CtxW = $bits(ctx_t);

  // Magnitudes and signs of dx/dy, halved when either reaches 2^31
  function automatic ctx_t split(ctx_t c);
    logic [32:0] ax;
    logic [32:0] ay;
    logic        big;
    ax  = c.dx[32] ? 33'(-c.dx) : 33'(c.dx);
    ay  = c.dy[32] ? 33'(-c.dy) : 33'(c.dy);
    big = ax[32] | ax[31] | ay[32] | ay[31];
    split      = c;
    split.negx = c.dx[32];
    split.negy = c.dy[32];
    split.sh   = big;
    split.mx   = big ? ax[31:1] : ax[30:0];
    split.my   = big ? ay[31:1] : ay[30:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [42:0] v);
    if (v[42:31] == {12{v[42]}}) begin
      return v[31:0];
    end
    return v[42] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  // Target plus signed pursue offset, saturated
  function automatic logic signed [31:0] aim_add(logic signed [31:0] t, logic neg,
                                                 logic [40:0] off);
    logic signed [42:0] o;
    o = $signed({2'b00, off});
    if (neg) begin
      o = -o;
    end
    return sat32(43'(t) + o);
  endfunction

  // Signed desired component minus agent velocity
  function automatic logic signed [32:0] force_comp(logic [30:0] q, logic neg,
                                                    logic signed [31:0] v);
    logic signed [32:0] fq;
    fq = $signed({2'b00, q});
    if (neg) begin
      fq = -fq;
    end
    return fq - 33'(v);
  endfunction

  function automatic logic [32:0] scaled_len(logic [RootW-1:0] len, logic sh);
    return sh ? {len, 1'b0} : {1'b0, len};
  endfunction

  // Configuration registers
  logic [CfgW-1:0] ms_q, mf_q, sr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q <= MaxSpeedRst;
      mf_q <= MaxForceRst;
      sr_q <= SlowRadRst;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_MAX_SPEED:      ms_q <= cfg_data_i;
        REG_MAX_FORCE:      mf_q <= cfg_data_i;
        REG_SLOWING_RADIUS: sr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result waits at the output
  logic adv;
  logic out_v_q;
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  // Stage registers
  logic        s0_v_q, a1_v_q, a2_v_q, a3_v_q, a4_v_q, a5_v_q, a6_v_q;
  logic        b1_v_q, b2_v_q, b3_v_q, b4_v_q, b5_v_q, b6_v_q, b7_v_q;
  logic        c2_v_q, c3_v_q, c4_v_q, c5_v_q;
  ctx_t        s0_q, s0_d, a1_q, a1_d, a2_q, a3_q, a4_q, a5_q, a5_d, a6_q, a6_d;
  ctx_t        b1_q, b1_d, b2_q, b3_q, b4_q, b5_q, b5_d, b6_q, b6_d, b7_q, b7_d;
  ctx_t        c2_q, c3_q, c4_q, c5_q, c5_d;
  logic [61:0] a3_sqx_q, a3_sqy_q, b3_sqx_q, b3_sqy_q, c3_sqx_q, c3_sqy_q;
  logic [62:0] a4_sum_q, b4_sum_q, c4_sum_q;
  logic [64:0] a5_px_q, a5_py_q, a5_px_d, a5_py_d;
  logic [61:0] b5_px_q, b5_py_q, b5_px_d, b5_py_d;
  logic [61:0] b6_px_q, b6_py_q, b6_px_d, b6_py_d;
  logic [61:0] c5_px_q, c5_py_q, c5_px_d, c5_py_d;
  logic signed [31:0] fx_q, fy_q, fx_d, fy_d, aimx_q, aimy_q;

  // Unit outputs
  logic             sa_v, sb_v, sc_v, dp_v, dq_v, dr_v, df_v;
  logic [RootW-1:0] sa_root, sb_root, sc_root;
  ctx_t             sa_ctx, sb_ctx, sc_ctx, dp_ctx, dq_ctx, dr_ctx, df_ctx, dp_in;
  logic [40:0]      dp_qx, dp_qy;
  logic [30:0]      dq_qx, dq_qy, dr_qx, dr_qy, df_qx, df_qy;

  // Capture the item
  always_comb begin
    s0_d     = '0;
    s0_d.op  = op_e'(operation_i);
    s0_d.px  = agent_x_i;
    s0_d.py  = agent_y_i;
    s0_d.vx  = agent_vx_i;
    s0_d.vy  = agent_vy_i;
    s0_d.tx  = target_x_i;
    s0_d.ty  = target_y_i;
    s0_d.tvx = target_vx_i;
    s0_d.tvy = target_vy_i;
  end

  // Pursue: agent-to-target difference
  always_comb begin
    a1_d    = s0_q;
    a1_d.dx = 33'(s0_q.tx) - 33'(s0_q.px);
    a1_d.dy = 33'(s0_q.ty) - 33'(s0_q.py);
  end

  sfu_sqrt #(.RtW(RootW), .SideW(CtxW)) u_sqrt_a (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(a4_v_q),
    .rad_i(64'(a4_sum_q)), .side_i(a4_q),
    .valid_o(sa_v), .root_o(sa_root), .side_o(sa_ctx)
  );

  // Pursue: |target velocity| times distance
  always_comb begin
    logic [32:0] reach;
    logic [31:0] atx;
    logic [31:0] aty;
    reach    = scaled_len(sa_root, sa_ctx.sh);
    atx      = sa_ctx.tvx[31] ? 32'(-sa_ctx.tvx) : 32'(sa_ctx.tvx);
    aty      = sa_ctx.tvy[31] ? 32'(-sa_ctx.tvy) : 32'(sa_ctx.tvy);
    a5_d     = sa_ctx;
    a5_d.len = sa_root;
    a5_px_d  = 65'(atx) * 65'(reach);
    a5_py_d  = 65'(aty) * 65'(reach);
  end

  // Flag quotients that reach 2^41 before dividing
  always_comb begin
    dp_in      = a5_q;
    dp_in.capx = ({7'd0, a5_px_q[64:41]} >= ms_q);
    dp_in.capy = ({7'd0, a5_py_q[64:41]} >= ms_q);
  end

  sfu_div #(.NumW(65), .DenW(CfgW), .QuoW(41), .SideW(CtxW)) u_div_p (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(a5_v_q),
    .num_x_i(a5_px_q), .num_y_i(a5_py_q), .den_i(ms_q), .side_i(dp_in),
    .valid_o(dp_v), .quo_x_o(dp_qx), .quo_y_o(dp_qy), .side_o(dp_ctx)
  );

  // Pursue: predicted aim point
  always_comb begin
    logic [40:0] offx;
    logic [40:0] offy;
    offx = (dp_ctx.capx || dp_qx > PursueCap) ? PursueCap : dp_qx;
    offy = (dp_ctx.capy || dp_qy > PursueCap) ? PursueCap : dp_qy;
    a6_d = dp_ctx;
    if (dp_ctx.op == OP_PURSUE && ms_q != '0) begin
      a6_d.tx = aim_add(dp_ctx.tx, dp_ctx.tvx[31], offx);
      a6_d.ty = aim_add(dp_ctx.ty, dp_ctx.tvy[31], offy);
    end
  end

  // Direction toward the aim point, away from it for flee
  always_comb begin
    b1_d = a6_q;
    if (a6_q.op == OP_FLEE) begin
      b1_d.dx = 33'(a6_q.px) - 33'(a6_q.tx);
      b1_d.dy = 33'(a6_q.py) - 33'(a6_q.ty);
    end else begin
      b1_d.dx = 33'(a6_q.tx) - 33'(a6_q.px);
      b1_d.dy = 33'(a6_q.ty) - 33'(a6_q.py);
    end
  end

  sfu_sqrt #(.RtW(RootW), .SideW(CtxW)) u_sqrt_b (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(b4_v_q),
    .rad_i(64'(b4_sum_q)), .side_i(b4_q),
    .valid_o(sb_v), .root_o(sb_root), .side_o(sb_ctx)
  );

  // Desired velocity numerators
  always_comb begin
    b5_d     = sb_ctx;
    b5_d.len = sb_root;
    b5_px_d  = 62'(sb_ctx.mx) * 62'(ms_q);
    b5_py_d  = 62'(sb_ctx.my) * 62'(ms_q);
  end

  sfu_div #(.NumW(62), .DenW(RootW), .QuoW(31), .SideW(CtxW)) u_div_q (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(b5_v_q),
    .num_x_i(b5_px_q), .num_y_i(b5_py_q), .den_i(b5_q.len), .side_i(b5_q),
    .valid_o(dq_v), .quo_x_o(dq_qx), .quo_y_o(dq_qy), .side_o(dq_ctx)
  );

  // Zero direction gives zero; set up arrive scaling
  always_comb begin
    logic [32:0] reach;
    reach    = scaled_len(dq_ctx.len, dq_ctx.sh);
    b6_d     = dq_ctx;
    b6_d.qx  = (dq_ctx.len != '0) ? dq_qx : '0;
    b6_d.qy  = (dq_ctx.len != '0) ? dq_qy : '0;
    b6_d.flg = (dq_ctx.op == OP_ARRIVE) && (reach < {2'b00, sr_q});
    b6_px_d  = 62'(b6_d.qx) * 62'(reach[30:0]);
    b6_py_d  = 62'(b6_d.qy) * 62'(reach[30:0]);
  end

  sfu_div #(.NumW(62), .DenW(CfgW), .QuoW(31), .SideW(CtxW)) u_div_r (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(b6_v_q),
    .num_x_i(b6_px_q), .num_y_i(b6_py_q), .den_i(sr_q), .side_i(b6_q),
    .valid_o(dr_v), .quo_x_o(dr_qx), .quo_y_o(dr_qy), .side_o(dr_ctx)
  );

  // Raw steering force
  always_comb begin
    b7_d = dr_ctx;
    if (dr_ctx.flg) begin
      b7_d.qx = dr_qx;
      b7_d.qy = dr_qy;
    end
    b7_d.dx = force_comp(b7_d.qx, dr_ctx.negx, dr_ctx.vx);
    b7_d.dy = force_comp(b7_d.qy, dr_ctx.negy, dr_ctx.vy);
  end

  sfu_sqrt #(.RtW(RootW), .SideW(CtxW)) u_sqrt_c (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(c4_v_q),
    .rad_i(64'(c4_sum_q)), .side_i(c4_q),
    .valid_o(sc_v), .root_o(sc_root), .side_o(sc_ctx)
  );

  // Clamp decision and numerators
  always_comb begin
    c5_d     = sc_ctx;
    c5_d.len = sc_root;
    c5_d.flg = (scaled_len(sc_root, sc_ctx.sh) > {2'b00, mf_q});
    c5_px_d  = 62'(sc_ctx.mx) * 62'(mf_q);
    c5_py_d  = 62'(sc_ctx.my) * 62'(mf_q);
  end

  sfu_div #(.NumW(62), .DenW(RootW), .QuoW(31), .SideW(CtxW)) u_div_f (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(c5_v_q),
    .num_x_i(c5_px_q), .num_y_i(c5_py_q), .den_i(c5_q.len), .side_i(c5_q),
    .valid_o(df_v), .quo_x_o(df_qx), .quo_y_o(df_qy), .side_o(df_ctx)
  );

  // Final force
  always_comb begin
    if (df_ctx.flg) begin
      fx_d = df_ctx.negx ? -$signed({1'b0, df_qx}) : $signed({1'b0, df_qx});
      fy_d = df_ctx.negy ? -$signed({1'b0, df_qy}) : $signed({1'b0, df_qy});
    end else begin
      fx_d = sat32(43'(df_ctx.dx));
      fy_d = sat32(43'(df_ctx.dy));
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      a1_v_q  <= 1'b0;
      a2_v_q  <= 1'b0;
      a3_v_q  <= 1'b0;
      a4_v_q  <= 1'b0;
      a5_v_q  <= 1'b0;
      a6_v_q  <= 1'b0;
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      b4_v_q  <= 1'b0;
      b5_v_q  <= 1'b0;
      b6_v_q  <= 1'b0;
      b7_v_q  <= 1'b0;
      c2_v_q  <= 1'b0;
      c3_v_q  <= 1'b0;
      c4_v_q  <= 1'b0;
      c5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s0_v_q  <= in_valid_i;
      a1_v_q  <= s0_v_q;
      a2_v_q  <= a1_v_q;
      a3_v_q  <= a2_v_q;
      a4_v_q  <= a3_v_q;
      a5_v_q  <= sa_v;
      a6_v_q  <= dp_v;
      b1_v_q  <= a6_v_q;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q;
      b4_v_q  <= b3_v_q;
      b5_v_q  <= sb_v;
      b6_v_q  <= dq_v;
      b7_v_q  <= dr_v;
      c2_v_q  <= b7_v_q;
      c3_v_q  <= c2_v_q;
      c4_v_q  <= c3_v_q;
      c5_v_q  <= sc_v;
      out_v_q <= df_v;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q     <= s0_d;
      a1_q     <= a1_d;
      a2_q     <= split(a1_q);
      a3_q     <= a2_q;
      a3_sqx_q <= 62'(a2_q.mx) * 62'(a2_q.mx);
      a3_sqy_q <= 62'(a2_q.my) * 62'(a2_q.my);
      a4_q     <= a3_q;
      a4_sum_q <= 63'(a3_sqx_q) + 63'(a3_sqy_q);
      a5_q     <= a5_d;
      a5_px_q  <= a5_px_d;
      a5_py_q  <= a5_py_d;
      a6_q     <= a6_d;
      b1_q     <= b1_d;
      b2_q     <= split(b1_q);
      b3_q     <= b2_q;
      b3_sqx_q <= 62'(b2_q.mx) * 62'(b2_q.mx);
      b3_sqy_q <= 62'(b2_q.my) * 62'(b2_q.my);
      b4_q     <= b3_q;
      b4_sum_q <= 63'(b3_sqx_q) + 63'(b3_sqy_q);
      b5_q     <= b5_d;
      b5_px_q  <= b5_px_d;
      b5_py_q  <= b5_py_d;
      b6_q     <= b6_d;
      b6_px_q  <= b6_px_d;
      b6_py_q  <= b6_py_d;
      b7_q     <= b7_d;
      c2_q     <= split(b7_q);
      c3_q     <= c2_q;
      c3_sqx_q <= 62'(c2_q.mx) * 62'(c2_q.mx);
      c3_sqy_q <= 62'(c2_q.my) * 62'(c2_q.my);
      c4_q     <= c3_q;
      c4_sum_q <= 63'(c3_sqx_q) + 63'(c3_sqy_q);
      c5_q     <= c5_d;
      c5_px_q  <= c5_px_d;
      c5_py_q  <= c5_py_d;
      fx_q     <= fx_d;
      fy_q     <= fy_d;
      aimx_q   <= df_ctx.tx;
      aimy_q   <= df_ctx.ty;
    end
  end

  assign out_valid_o = out_v_q;
  assign force_x_o   = fx_q;
  assign force_y_o   = fy_q;
  assign aim_x_o     = aimx_q;
  assign aim_y_o     = aimy_q;

endmodule

// ===== sv/sfu_chk.sv =====
`include "assert_macros.svh"

module sfu_chk
  import sfu_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [DataW-1:0] force_x_o,
  input logic signed [DataW-1:0] force_y_o,
  input logic signed [DataW-1:0] aim_x_o,
  input logic signed [DataW-1:0] aim_y_o
);

  // Hold a stalled result
  `SFU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(force_x_o) && $stable(force_y_o) && $stable(aim_x_o) && $stable(aim_y_o), "stalled result changed")

  // Input side stalls exactly when a result waits
  `SFU_ASSERT(a_ready_rule, in_ready_o == (!out_valid_o || out_ready_i), "ready does not follow output stall")

  // Reset empties the pipeline
  `SFU_ASSERT_NR(a_reset_empty, !rst_ni |=> !out_valid_o, "result shown right after reset")

endmodule

bind steering_force_unit_core sfu_chk u_sfu_chk (.*);

// ===== dv/steering_force_checker.sv =====
`timescale 1ns / 100ps

module steering_force_checker
  import sfu_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [IdxW-1:0]         cfg_idx_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [1:0]              operation_i,
  input  logic signed [DataW-1:0] agent_x_i,
  input  logic signed [DataW-1:0] agent_y_i,
  input  logic signed [DataW-1:0] agent_vx_i,
  input  logic signed [DataW-1:0] agent_vy_i,
  input  logic signed [DataW-1:0] target_x_i,
  input  logic signed [DataW-1:0] target_y_i,
  input  logic signed [DataW-1:0] target_vx_i,
  input  logic signed [DataW-1:0] target_vy_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic signed [DataW-1:0] force_x_i,
  input  logic signed [DataW-1:0] force_y_i,
  input  logic signed [DataW-1:0] aim_x_i,
  input  logic signed [DataW-1:0] aim_y_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
  } steer_t;

  // Vector length measure: magnitudes, signs, halving flag, root
  typedef struct {
    logic [63:0] ax;
    logic [63:0] ay;
    bit          nx;
    bit          ny;
    bit          sh;
    logic [63:0] len;
  } vlen_t;

  steer_t      steer_q[$];
  logic [63:0] speed_r, force_lim_r, radius_r;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic vlen_t measure_vec(longint dx, longint dy);
    vlen_t m;
    m.nx = dx < 0;
    m.ny = dy < 0;
    m.ax = m.nx ? -dx : dx;
    m.ay = m.ny ? -dy : dy;
    m.sh = 0;
    if (m.ax >= 64'h8000_0000 || m.ay >= 64'h8000_0000) begin
      m.ax >>= 1;
      m.ay >>= 1;
      m.sh = 1;
    end
    m.len = root64(m.ax * m.ax + m.ay * m.ay);
    return m;
  endfunction

  function automatic longint signed_of(logic [63:0] v, bit neg);
    return neg ? -longint'(v) : longint'(v);
  endfunction

  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // trunc(a*b/c) capped at 2^40
  function automatic logic [63:0] scale_capped(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] c);
    logic [63:0] q, r, hi, cap;
    q = b / c;
    r = b % c;
    cap = 64'd1 << 40;
    hi = a * q;
    if (hi > cap) return cap;
    hi += (a * r) / c;
    return hi > cap ? cap : hi;
  endfunction

  function automatic steer_t predict_steer(op_e op, longint px, longint py,
                                           longint vx, longint vy, longint tx,
                                           longint ty, longint tvx, longint tvy);
    vlen_t       m;
    logic [63:0] qx, qy, reach;
    longint      fx, fy;
    steer_t      s;
    qx = 0;
    qy = 0;
    // Predict the target position for pursue
    if (op == OP_PURSUE) begin
      m = measure_vec(tx - px, ty - py);
      reach = m.len << m.sh;
      if (speed_r != 0) begin
        tx = clip32(tx + signed_of(scale_capped(tvx < 0 ? -tvx : tvx, reach, speed_r),
                                   tvx < 0));
        ty = clip32(ty + signed_of(scale_capped(tvy < 0 ? -tvy : tvy, reach, speed_r),
                                   tvy < 0));
      end
    end
    if (op == OP_FLEE) m = measure_vec(px - tx, py - ty);
    else m = measure_vec(tx - px, ty - py);
    reach = m.len << m.sh;
    // Desired velocity, shrunk inside the slowing radius for arrive
    if (m.len != 0) begin
      qx = m.ax * speed_r / m.len;
      qy = m.ay * speed_r / m.len;
      if (op == OP_ARRIVE && reach < radius_r) begin
        qx = qx * reach / radius_r;
        qy = qy * reach / radius_r;
      end
    end
    fx = signed_of(qx, m.nx) - vx;
    fy = signed_of(qy, m.ny) - vy;
    // Clamp the force length
    m = measure_vec(fx, fy);
    if ((m.len << m.sh) > force_lim_r) begin
      fx = signed_of(m.ax * force_lim_r / m.len, m.nx);
      fy = signed_of(m.ay * force_lim_r / m.len, m.ny);
    end
    s.fx = 32'(clip32(fx));
    s.fy = 32'(clip32(fy));
    s.ax = 32'(tx);
    s.ay = 32'(ty);
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = steer_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    steer_t e;
    if (!rst_ni) begin
      speed_r      <= 64'(MaxSpeedRst);
      force_lim_r  <= 64'(MaxForceRst);
      radius_r     <= 64'(SlowRadRst);
      fail_count_o = 0;
      steer_q.delete();
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_MAX_SPEED:      speed_r     <= 64'(cfg_data_i);
          REG_MAX_FORCE:      force_lim_r <= 64'(cfg_data_i);
          REG_SLOWING_RADIUS: radius_r    <= 64'(cfg_data_i);
          default: ;
        endcase
      end
      // Compare the result item with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (steer_q.size() == 0) begin
          report_mismatch("unexpected item", force_x_i, 0);
        end else begin
          e = steer_q.pop_front();
          if (force_x_i !== e.fx) report_mismatch("force_x", force_x_i, e.fx);
          if (force_y_i !== e.fy) report_mismatch("force_y", force_y_i, e.fy);
          if (aim_x_i !== e.ax) report_mismatch("aim_x", aim_x_i, e.ax);
          if (aim_y_i !== e.ay) report_mismatch("aim_y", aim_y_i, e.ay);
        end
      end
      // Predict each accepted item
      if (in_valid_i && in_ready_i)
        steer_q.push_back(predict_steer(op_e'(operation_i), agent_x_i, agent_y_i,
                                        agent_vx_i, agent_vy_i, target_x_i, target_y_i,
                                        target_vx_i, target_vy_i));
    end
  end

endmodule

// ===== dv/steering_force_unit_core_tb.sv =====
`timescale 1ns / 100ps

module steering_force_unit_core_tb;
  import sfu_pkg::*;

  logic                    clk_i, rst_ni;
  logic                    cfg_we_i;
  logic [IdxW-1:0]         cfg_idx_i;
  logic [CfgW-1:0]         cfg_data_i;
  logic                    in_valid_i, in_ready_o;
  logic [1:0]              operation_i;
  logic signed [DataW-1:0] agent_x_i, agent_y_i, agent_vx_i, agent_vy_i;
  logic signed [DataW-1:0] target_x_i, target_y_i, target_vx_i, target_vy_i;
  logic                    out_valid_o, out_ready_i;
  logic signed [DataW-1:0] force_x_o, force_y_o, aim_x_o, aim_y_o;
  int                      fail_count, pending;
  bit                      calm, hold_off;

  steering_force_unit_core u_top (.*);

  steering_force_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i,
    .agent_x_i, .agent_y_i, .agent_vx_i, .agent_vy_i,
    .target_x_i, .target_y_i, .target_vx_i, .target_vy_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .force_x_i(force_x_o), .force_y_i(force_y_o), .aim_x_i(aim_x_o), .aim_y_i(aim_y_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, a calm stretch, and one long hold-off
  initial begin
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      out_ready_i <= calm || ($urandom_range(99) >= 10);
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 0;
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(2000000)) - 1000000) <<< 6;
    endcase
  endfunction

  task automatic send_item(op_e op, logic [31:0] px, logic [31:0] py, logic [31:0] vx,
                           logic [31:0] vy, logic [31:0] tx, logic [31:0] ty,
                           logic [31:0] tvx, logic [31:0] tvy);
    // Idle now and then before offering the item
    while (!calm && $urandom_range(99) < 10) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1;
    operation_i <= op;
    agent_x_i   <= px;
    agent_y_i   <= py;
    agent_vx_i  <= vx;
    agent_vy_i  <= vy;
    target_x_i  <= tx;
    target_y_i  <= ty;
    target_vx_i <= tvx;
    target_vy_i <= tvy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_random();
    send_item(op_e'($urandom_range(3)), pick_value(), pick_value(), pick_value(),
              pick_value(), pick_value(), pick_value(), pick_value(), pick_value());
  endtask

  // Drain everything, then write the three registers while idle
  task automatic set_regs(logic [30:0] speed, logic [30:0] flim, logic [30:0] rad);
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= REG_MAX_SPEED;
    cfg_data_i <= speed;
    @(posedge clk_i);
    cfg_idx_i <= REG_MAX_FORCE;
    cfg_data_i <= flim;
    @(posedge clk_i);
    cfg_idx_i <= REG_SLOWING_RADIUS;
    cfg_data_i <= rad;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  initial begin
    logic [30:0] speeds[6], forces[6], radii[6];
    int wait_cycles;
    speeds = '{31'd6553600, 0, 31'h7fff_ffff, 31'd65536, 31'd1 << 24, 31'd12345};
    forces = '{31'd327680, 31'h7fff_ffff, 0, 31'd1 << 20, 31'd65536, 31'h7fff_ffff};
    radii  = '{31'd9830400, 31'h7fff_ffff, 31'd1 << 26, 0, 31'd1 << 30, 31'd65536};
    rst_ni = 0;
    cfg_we_i = 0; cfg_idx_i = REG_MAX_SPEED; cfg_data_i = 0;
    in_valid_i = 0; operation_i = OP_SEEK;
    agent_x_i = 0; agent_y_i = 0; agent_vx_i = 0; agent_vy_i = 0;
    target_x_i = 0; target_y_i = 0; target_vx_i = 0; target_vy_i = 0;
    calm = 0; hold_off = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: each operation, zero direction, field extremes
    send_item(OP_SEEK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_FLEE, 5, 5, 7, -7, 5, 5, 0, 0);
    send_item(OP_ARRIVE, 0, 0, 0, 0, 32'd65536 * 10, 32'd65536 * 20, 0, 0);
    send_item(OP_ARRIVE, 0, 0, 0, 0, 32'd65536 * 400, 0, 0, 0);
    send_item(OP_PURSUE, 0, 0, 0, 0, 32'd65536 * 50, 32'd65536, 32'h7fff_ffff, 32'h8000_0000);
    send_item(OP_SEEK, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
    send_item(OP_FLEE, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_PURSUE, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 0,
              32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_item(OP_ARRIVE, 32'h8000_0000, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0);
    send_item(OP_PURSUE, 10, 10, 0, 0, 10, 10, 32'h7fff_ffff, 32'h7fff_ffff);

    // Random phases across register settings; zero speed, force and radius included
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(speeds[ph], forces[ph], radii[ph]);
      for (int n = 0; n < 240; n++) begin
        calm = (ph == 2 && n >= 60 && n < 180);
        if (ph == 1 && n == 20) hold_off = 1;
        send_random();
      end
    end
    calm = 0;
    in_valid_i <= 0;

    // Drain
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sfu_pkg.sv
sv/sfu_div.sv
sv/sfu_sqrt.sv
sv/steering_force_unit_core.sv
sv/sfu_chk.sv
dv/steering_force_checker.sv
dv/steering_force_unit_core_tb.sv
